### sv/scdu_pkg.sv
// shared types and constants of the sequenced channel delivery unit
`default_nettype none

package scdu_pkg;

    localparam int CH_W     = 5;
    localparam int SEQ_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int ENTRY_W  = SEQ_W + HANDLE_W;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [SEQ_W-1:0] DIST_LIMIT = 16'h7FFF;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_DRAIN  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDERED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELIABLE = 1'b1;

    localparam logic [1:0] MODE_UNORDERED = 2'd0;
    localparam logic [1:0] MODE_RELIABLE  = 2'd1;
    localparam logic [1:0] MODE_LATEST    = 2'd2;

    typedef struct packed {
        logic load;
        logic arrive;
        logic start;
        logic rd_scan;
        logic take;
        logic skip;
        logic rd_move;
        logic move_wr;
        logic scan_end;
        logic fin;
    } scdu_cmd_t;

    typedef struct packed {
        logic       in_range;
        logic [1:0] mode;
        logic       scan_done;
        logic       hit;
        logic       held_v;
        logic       can_push;
    } scdu_stat_t;

endpackage

`default_nettype wire

### sv/scdu_if.sv
// word channels of the sequenced channel delivery unit
`default_nettype none

interface scdu_item_if;
    import scdu_pkg::*;
    logic                valid;
    logic                ready;
    logic                func;
    logic [CH_W-1:0]     channel;
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] payload_handle;
    modport source (output valid, func, channel, seq, payload_handle, input ready);
    modport sink   (input valid, func, channel, seq, payload_handle, output ready);
endinterface

interface scdu_result_if;
    import scdu_pkg::*;
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     out_channel;
    logic                has_message;
    logic [HANDLE_W-1:0] out_handle;
    logic [SEQ_W-1:0]    out_seq;
    logic                overflowed;
    logic                last;
    modport source (output valid, out_channel, has_message, out_handle, out_seq,
                    overflowed, last, input ready);
    modport sink   (input valid, out_channel, has_message, out_handle, out_seq,
                    overflowed, last, output ready);
endinterface

interface scdu_cfg_if;
    import scdu_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/scdu_ctrl.sv
// controller state machine of the sequenced channel delivery unit
`default_nettype none

module scdu_ctrl
    import scdu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_func,
    output logic            in_ready,
    input  wire scdu_stat_t stat,
    output scdu_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ARR     = 3'd1;
    localparam logic [2:0] ST_START   = 3'd2;
    localparam logic [2:0] ST_SCAN    = 3'd3;
    localparam logic [2:0] ST_CHECK   = 3'd4;
    localparam logic [2:0] ST_MOVE    = 3'd5;
    localparam logic [2:0] ST_MOVE_WR = 3'd6;
    localparam logic [2:0] ST_FIN     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign slot_free = !stat.held_v || stat.can_push;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_func == FUNC_DRAIN) ? ST_START : ST_ARR;
                end
            end
            ST_ARR:
            begin
                cmd.arrive = 1'b1;
                state_next = ST_IDLE;
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = stat.in_range ? ST_SCAN : ST_FIN;
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.scan_end = 1'b1;
                    state_next   = ST_FIN;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                case (stat.mode)
                    MODE_UNORDERED:
                    begin
                        if (slot_free)
                        begin
                            cmd.take   = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                    MODE_RELIABLE:
                    begin
                        if (!stat.hit)
                        begin
                            cmd.skip   = 1'b1;
                            state_next = ST_SCAN;
                        end
                        else if (slot_free)
                        begin
                            cmd.take   = 1'b1;
                            state_next = ST_MOVE;
                        end
                    end
                    default:
                    begin
                        cmd.skip   = 1'b1;
                        state_next = ST_SCAN;
                    end
                endcase
            end
            ST_MOVE:
            begin
                cmd.rd_move = 1'b1;
                state_next  = ST_MOVE_WR;
            end
            ST_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_FIN:
            begin
                if (stat.can_push)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### sv/scdu_dp.sv
// datapath of the sequenced channel delivery unit: queues, channel state, output word
`default_nettype none

module scdu_dp
    import scdu_pkg::*;
#(
    parameter int NUM_CHANNELS = 32,
    parameter int QUEUE_DEPTH  = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [CH_W-1:0]      in_channel,
    input  wire logic [SEQ_W-1:0]     in_seq,
    input  wire logic [HANDLE_W-1:0]  in_handle,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [CH_W-1:0]           out_channel,
    output logic                      out_has,
    output logic [HANDLE_W-1:0]       out_handle,
    output logic [SEQ_W-1:0]          out_seq,
    output logic                      out_ovf,
    output logic                      out_last,
    input  wire scdu_cmd_t            cmd,
    output scdu_stat_t                stat
);

    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CHI_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MEM_DEPTH = NUM_CHANNELS * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [CH_W-1:0]     ch_reg;
    logic [ENTRY_W-1:0]  entry_in_reg;
    logic [31:0]         ordered_reg;
    logic [31:0]         reliable_reg;
    logic [CNT_W-1:0]    count_reg [NUM_CHANNELS];
    logic [SEQ_W-1:0]    lastseq_reg [NUM_CHANNELS];
    logic                ovflag_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                held_v_reg;
    logic [ENTRY_W-1:0]  held_reg;
    logic                best_have_reg;
    logic [SEQ_W-1:0]    best_dist_reg;
    logic [ENTRY_W-1:0]  best_reg;
    logic                ovf_lat_reg;
    logic [ENTRY_W-1:0]  mem [MEM_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic                out_valid_reg;
    logic [CH_W-1:0]     out_channel_reg;
    logic                out_has_reg;
    logic [ENTRY_W-1:0]  out_entry_reg;
    logic                out_ovf_reg;
    logic                out_last_reg;

    logic [CHI_W-1:0]    chi;
    logic                in_range;
    logic [1:0]          mode;
    logic [SEQ_W-1:0]    want;
    logic [SEQ_W-1:0]    rd_seq;
    logic [SEQ_W-1:0]    gap;
    logic                full;
    logic                can_push;
    logic                push_mid;
    logic [ADDR_W-1:0]   base;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    assign chi      = ch_reg[CHI_W-1:0];
    assign in_range = {1'b0, ch_reg} < (CH_W + 1)'(NUM_CHANNELS);
    assign want     = lastseq_reg[chi] + 1'b1;
    assign rd_seq   = rd_data_reg[ENTRY_W-1:HANDLE_W];
    assign gap      = rd_seq - lastseq_reg[chi];
    assign full     = (count_reg[chi] == CNT_W'(QUEUE_DEPTH));
    assign can_push = !out_valid_reg || out_ready;
    assign push_mid = cmd.take && held_v_reg;
    assign base     = ADDR_W'(chi) * ADDR_W'(QUEUE_DEPTH);

    always_comb
    begin
        if (!ordered_reg[ch_reg])
        begin
            mode = MODE_UNORDERED;
        end
        else if (reliable_reg[ch_reg])
        begin
            mode = MODE_RELIABLE;
        end
        else
        begin
            mode = MODE_LATEST;
        end
    end

    assign stat.in_range  = in_range;
    assign stat.mode      = mode;
    assign stat.scan_done = (idx_reg == cnt_reg);
    assign stat.hit       = (rd_seq == want);
    assign stat.held_v    = held_v_reg;
    assign stat.can_push  = can_push;

    assign mem_we    = (cmd.arrive && in_range && !full) || cmd.move_wr;
    assign mem_waddr = base + (cmd.move_wr ? ADDR_W'(idx_reg) : ADDR_W'(count_reg[chi]));
    assign mem_wdata = cmd.move_wr ? rd_data_reg : entry_in_reg;
    assign mem_raddr = base + (cmd.rd_move ? ADDR_W'(cnt_reg - 1'b1) : ADDR_W'(idx_reg));

    // queue storage
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_scan || cmd.rd_move)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg          <= '0;
            entry_in_reg    <= '0;
            ordered_reg     <= '0;
            reliable_reg    <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                count_reg[i]   <= '0;
                lastseq_reg[i] <= '0;
                ovflag_reg[i]  <= 1'b0;
            end
            cnt_reg         <= '0;
            idx_reg         <= '0;
            held_v_reg      <= 1'b0;
            held_reg        <= '0;
            best_have_reg   <= 1'b0;
            best_dist_reg   <= '0;
            best_reg        <= '0;
            ovf_lat_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_channel_reg <= '0;
            out_has_reg     <= 1'b0;
            out_entry_reg   <= '0;
            out_ovf_reg     <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ORDERED:  ordered_reg  <= cfg_data;
                    CFG_RELIABLE: reliable_reg <= cfg_data;
                    default:      ;
                endcase
            end

            if (cmd.load)
            begin
                ch_reg       <= in_channel;
                entry_in_reg <= {in_seq, in_handle};
            end

            if (cmd.arrive && in_range)
            begin
                if (full)
                begin
                    ovflag_reg[chi] <= 1'b1;
                end
                else
                begin
                    count_reg[chi] <= count_reg[chi] + 1'b1;
                end
            end

            if (cmd.start)
            begin
                cnt_reg       <= in_range ? count_reg[chi] : '0;
                idx_reg       <= '0;
                held_v_reg    <= 1'b0;
                best_have_reg <= 1'b0;
                best_dist_reg <= '0;
                ovf_lat_reg   <= in_range && ovflag_reg[chi];
            end

            if (cmd.take)
            begin
                held_reg   <= rd_data_reg;
                held_v_reg <= 1'b1;
                if (mode == MODE_RELIABLE)
                begin
                    lastseq_reg[chi] <= want;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            if (cmd.skip)
            begin
                if (mode == MODE_LATEST && gap < DIST_LIMIT && gap > best_dist_reg)
                begin
                    best_dist_reg <= gap;
                    best_reg      <= rd_data_reg;
                    best_have_reg <= 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.move_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                idx_reg <= '0;
            end

            if (cmd.scan_end)
            begin
                case (mode)
                    MODE_RELIABLE:
                    begin
                        count_reg[chi] <= cnt_reg;
                    end
                    MODE_LATEST:
                    begin
                        count_reg[chi] <= '0;
                        if (best_have_reg)
                        begin
                            held_reg         <= best_reg;
                            held_v_reg       <= 1'b1;
                            lastseq_reg[chi] <= best_reg[ENTRY_W-1:HANDLE_W];
                        end
                    end
                    default:
                    begin
                        count_reg[chi] <= '0;
                    end
                endcase
            end

            if (cmd.fin && in_range)
            begin
                ovflag_reg[chi] <= 1'b0;
            end

            // output word register
            if (push_mid || cmd.fin)
            begin
                out_valid_reg   <= 1'b1;
                out_channel_reg <= ch_reg;
                out_has_reg     <= held_v_reg;
                out_entry_reg   <= held_v_reg ? held_reg : '0;
                out_ovf_reg     <= ovf_lat_reg;
                out_last_reg    <= cmd.fin;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign out_has     = out_has_reg;
    assign out_handle  = out_entry_reg[HANDLE_W-1:0];
    assign out_seq     = out_entry_reg[ENTRY_W-1:HANDLE_W];
    assign out_ovf     = out_ovf_reg;
    assign out_last    = out_last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH) && idx_reg <= cnt_reg)
        else $error("scan index or count beyond queue depth");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_has_reg |-> out_last_reg)
        else $error("empty word not marked last");

    a_fin_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> out_valid_reg && out_last_reg)
        else $error("drain finished without a last word");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_mid || cmd.fin) |-> can_push)
        else $error("output word overwritten before taken");
`endif

endmodule

`default_nettype wire

### sv/sequenced_channel_delivery_unit.sv
// top level of the sequenced channel delivery unit
`default_nettype none

// Per-channel reorder queues for up to NUM_CHANNELS channels of QUEUE_DEPTH
// entries each, held in one memory with a single registered read port. An
// arrive word is accepted and then written to its channel's queue. A drain is
// accepted, starts and ends its scan and finishes; each queue entry visited is
// read through the one read port and then checked. A reliable drain moves the
// tail entry into the slot of each delivered message and then restarts its
// scan.
// One word is accepted at a time; a stalled output word holds the drain.
// Configuration writes are taken in any cycle. Queue memory needs no clearing.
module sequenced_channel_delivery_unit
    import scdu_pkg::*;
#(
    parameter int NUM_CHANNELS = 32,
    parameter int QUEUE_DEPTH  = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    scdu_item_if.sink   items,
    scdu_result_if.source results,
    scdu_cfg_if.sink    cfg
);

    scdu_cmd_t  cmd;
    scdu_stat_t stat;

    assign cfg.ready = 1'b1;

    scdu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_func  (items.func),
        .in_ready (items.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scdu_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_channel  (items.channel),
        .in_seq      (items.seq),
        .in_handle   (items.payload_handle),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_valid   (results.valid),
        .out_ready   (results.ready),
        .out_channel (results.out_channel),
        .out_has     (results.has_message),
        .out_handle  (results.out_handle),
        .out_seq     (results.out_seq),
        .out_ovf     (results.overflowed),
        .out_last    (results.last),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

### test/scdu_checker.sv
// checker of the sequenced channel delivery unit: predicts results and compares them
`timescale 1ns / 100ps

module scdu_checker
    import scdu_pkg::*;
#(
    parameter int NUM_CHANNELS = 32,
    parameter int QUEUE_DEPTH  = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    scdu_item_if      items,
    scdu_result_if    results,
    scdu_cfg_if       cfg,
    output int        fail_count,
    output int        pending_count,
    output logic      accepted
);

    typedef struct packed {
        logic [CH_W-1:0]     chan;
        logic                has;
        logic [HANDLE_W-1:0] handle;
        logic [SEQ_W-1:0]    seq;
        logic                ovf;
        logic                fin;
    } delivery_t;

    logic [CFG_W-1:0]    ordered_bits;
    logic [CFG_W-1:0]    reliable_bits;
    logic [SEQ_W-1:0]    q_seq [NUM_CHANNELS][QUEUE_DEPTH];
    logic [HANDLE_W-1:0] q_handle [NUM_CHANNELS][QUEUE_DEPTH];
    int                  q_count [NUM_CHANNELS];
    logic [SEQ_W-1:0]    delivered_seq [NUM_CHANNELS];
    logic                dropped [NUM_CHANNELS];
    delivery_t           deliveries [$];

    assign pending_count = deliveries.size();
    assign accepted = (items.valid && items.ready) || (results.valid && results.ready);

    function automatic delivery_t make_delivery(logic [CH_W-1:0] ch, logic has,
                                                logic [HANDLE_W-1:0] h,
                                                logic [SEQ_W-1:0] s, logic ovf);
        delivery_t d;
        d.chan = ch;
        d.has = has;
        d.handle = h;
        d.seq = s;
        d.ovf = ovf;
        d.fin = 1'b0;
        return d;
    endfunction

    task automatic predict_drain(int ch);
        delivery_t          batch [$];
        logic               ovf;
        int                 cnt;
        int                 best;
        logic [SEQ_W-1:0]   want;
        logic [SEQ_W-1:0]   gap;
        logic [SEQ_W-1:0]   best_dist;
        bit                 found;
        ovf = dropped[ch];
        cnt = q_count[ch];
        if (ordered_bits[ch] && reliable_bits[ch])
        begin
            found = 1;
            while (found && cnt > 0)
            begin
                want = delivered_seq[ch] + 1'b1;
                found = 0;
                for (int i = 0; i < cnt && !found; i++)
                begin
                    if (q_seq[ch][i] == want)
                    begin
                        batch = {batch, make_delivery(CH_W'(ch), 1'b1, q_handle[ch][i],
                                                      want, ovf)};
                        q_seq[ch][i] = q_seq[ch][cnt-1];
                        q_handle[ch][i] = q_handle[ch][cnt-1];
                        cnt--;
                        delivered_seq[ch] = want;
                        found = 1;
                    end
                end
            end
            q_count[ch] = cnt;
        end
        else if (ordered_bits[ch])
        begin
            best = -1;
            best_dist = '0;
            for (int i = 0; i < cnt; i++)
            begin
                gap = q_seq[ch][i] - delivered_seq[ch];
                if (gap < DIST_LIMIT && gap > best_dist)
                begin
                    best_dist = gap;
                    best = i;
                end
            end
            if (best >= 0)
            begin
                delivered_seq[ch] = q_seq[ch][best];
                batch = {batch, make_delivery(CH_W'(ch), 1'b1, q_handle[ch][best],
                                              q_seq[ch][best], ovf)};
            end
            q_count[ch] = 0;
        end
        else
        begin
            for (int i = 0; i < cnt; i++)
                batch = {batch, make_delivery(CH_W'(ch), 1'b1, q_handle[ch][i],
                                              q_seq[ch][i], ovf)};
            q_count[ch] = 0;
        end
        dropped[ch] = 1'b0;
        if (batch.size() == 0)
            batch = {batch, make_delivery(CH_W'(ch), 1'b0, '0, '0, ovf)};
        batch[batch.size()-1].fin = 1'b1;
        deliveries = {deliveries, batch};
    endtask

    task automatic compare_word();
        delivery_t e;
        if (deliveries.size() == 0)
        begin
            $error("unexpected result word on channel %0d", results.out_channel);
            fail_count++;
            return;
        end
        e = deliveries.pop_front();
        if (results.out_channel !== e.chan)
        begin
            $error("out_channel expected %0d actual %0d", e.chan, results.out_channel);
            fail_count++;
        end
        if (results.has_message !== e.has)
        begin
            $error("has_message expected %0d actual %0d", e.has, results.has_message);
            fail_count++;
        end
        if (results.out_handle !== e.handle)
        begin
            $error("out_handle expected %h actual %h", e.handle, results.out_handle);
            fail_count++;
        end
        if (results.out_seq !== e.seq)
        begin
            $error("out_seq expected %h actual %h", e.seq, results.out_seq);
            fail_count++;
        end
        if (results.overflowed !== e.ovf)
        begin
            $error("overflowed expected %0d actual %0d", e.ovf, results.overflowed);
            fail_count++;
        end
        if (results.last !== e.fin)
        begin
            $error("last expected %0d actual %0d", e.fin, results.last);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            ordered_bits <= '0;
            reliable_bits <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                q_count[c] = 0;
                delivered_seq[c] = '0;
                dropped[c] = 1'b0;
            end
            deliveries.delete();
        end
        else
        begin
            if (results.valid && results.ready)
                compare_word();
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_ORDERED)
                    ordered_bits <= cfg.data;
                else if (cfg.index == CFG_RELIABLE)
                    reliable_bits <= cfg.data;
            end
            if (items.valid && items.ready)
            begin
                if (items.channel >= NUM_CHANNELS)
                begin
                    if (items.func == FUNC_DRAIN)
                    begin
                        deliveries = {deliveries,
                                      make_delivery(items.channel, 1'b0, '0, '0, 1'b0)};
                        deliveries[deliveries.size()-1].fin = 1'b1;
                    end
                end
                else if (items.func == FUNC_ARRIVE)
                begin
                    if (q_count[items.channel] >= QUEUE_DEPTH)
                        dropped[items.channel] = 1'b1;
                    else
                    begin
                        q_seq[items.channel][q_count[items.channel]] = items.seq;
                        q_handle[items.channel][q_count[items.channel]] = items.payload_handle;
                        q_count[items.channel]++;
                    end
                end
                else
                    predict_drain(items.channel);
            end
        end
    end

endmodule

### test/tb_sequenced_channel_delivery_unit.sv
// testbench top of the sequenced channel delivery unit: stimulus and verdict
`timescale 1ns / 100ps

module tb_sequenced_channel_delivery_unit;
    import scdu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    logic accepted;
    int   idle_cycles;
    bit   calm;
    int   hold_off;
    bit   stall_go;
    bit   stall_seen;
    bit   done;

    scdu_item_if   items ();
    scdu_result_if results ();
    scdu_cfg_if    cfg ();

    sequenced_channel_delivery_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    scdu_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .items         (items),
        .results       (results),
        .cfg           (cfg),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .accepted      (accepted)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        items.valid = 1'b0;
        items.func = FUNC_ARRIVE;
        items.channel = '0;
        items.seq = '0;
        items.payload_handle = '0;
        results.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_ORDERED;
        cfg.data = '0;
        calm = 0;
        stall_go = 0;
        done = 0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_word(logic func, logic [CH_W-1:0] ch, logic [SEQ_W-1:0] s,
                             logic [HANDLE_W-1:0] h);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            items.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        items.valid <= 1'b1;
        items.func <= func;
        items.channel <= ch;
        items.seq <= s;
        items.payload_handle <= h;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    task automatic wait_settled();
        items.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_modes(logic [CFG_W-1:0] ord, logic [CFG_W-1:0] rel);
        wait_settled();
        write_reg(CFG_ORDERED, ord);
        write_reg(CFG_RELIABLE, rel);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_phase(int count, int lo_ch, int hi_ch);
        logic [CH_W-1:0]  ch;
        logic [SEQ_W-1:0] base;
        for (int n = 0; n < count; n++)
        begin
            ch = CH_W'($urandom_range(lo_ch, hi_ch));
            if ($urandom_range(0, 4) == 0)
                send_word(FUNC_DRAIN, ch, SEQ_W'($urandom), HANDLE_W'($urandom));
            else
            begin
                base = ($urandom_range(0, 3) == 0) ? SEQ_W'($urandom)
                                                   : SEQ_W'($urandom_range(0, 6));
                send_word(FUNC_ARRIVE, ch, base, HANDLE_W'($urandom));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_go && !stall_seen)
        begin
            stall_seen <= 1'b1;
            hold_off <= 300;
            results.ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            results.ready <= 1'b0;
        end
        else if (calm)
            results.ready <= 1'b1;
        else if (!results.ready)
            results.ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
        else
            results.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if (accepted || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sequenced_channel_delivery_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unordered: extremes, overflow, empty drain
        send_word(FUNC_DRAIN, 5'd0, 16'h0, 16'h0);
        send_word(FUNC_ARRIVE, 5'd31, 16'hFFFF, 16'hFFFF);
        send_word(FUNC_ARRIVE, 5'd31, 16'h0000, 16'h0000);
        send_word(FUNC_DRAIN, 5'd31, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 17; i++)
            send_word(FUNC_ARRIVE, 5'd3, 16'(i), 16'(16'hA000 + i));
        send_word(FUNC_DRAIN, 5'd3, 16'h0, 16'h0);
        send_word(FUNC_DRAIN, 5'd3, 16'h0, 16'h0);

        // reliable ordered with gap and duplicates
        set_modes(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(FUNC_ARRIVE, 5'd1, 16'd2, 16'h1112);
        send_word(FUNC_ARRIVE, 5'd1, 16'd1, 16'h1111);
        send_word(FUNC_ARRIVE, 5'd1, 16'd1, 16'h2222);
        send_word(FUNC_ARRIVE, 5'd1, 16'd4, 16'h1114);
        send_word(FUNC_DRAIN, 5'd1, 16'h0, 16'h0);
        send_word(FUNC_ARRIVE, 5'd1, 16'd3, 16'h1113);
        send_word(FUNC_DRAIN, 5'd1, 16'h0, 16'h0);

        // latest only: distance limit and ties
        set_modes(32'hFFFF_FFFF, 32'h0);
        send_word(FUNC_ARRIVE, 5'd2, 16'h7FFE, 16'h0001);
        send_word(FUNC_ARRIVE, 5'd2, 16'h7FFF, 16'h0002);
        send_word(FUNC_ARRIVE, 5'd2, 16'h7FFE, 16'h0003);
        send_word(FUNC_DRAIN, 5'd2, 16'h0, 16'h0);
        send_word(FUNC_ARRIVE, 5'd2, 16'h7FFE, 16'h0004);
        send_word(FUNC_DRAIN, 5'd2, 16'h0, 16'h0);

        // long receiver stall while the sender keeps pushing
        set_modes(32'h0, 32'h0);
        stall_go = 1;
        random_phase(30, 0, 3);
        for (int c = 0; c < 4; c++)
            send_word(FUNC_DRAIN, 5'(c), 16'h0, 16'h0);
        wait_settled();

        set_modes(32'hAAAA_AAAA, 32'h5555_AAAA);
        random_phase(45, 0, 7);
        set_modes(32'h0F0F_F0F0, 32'hFFFF_0000);
        random_phase(45, 0, 31);
        set_modes(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        calm = 1;
        random_phase(30, 0, 3);
        for (int c = 0; c < 32; c++)
            send_word(FUNC_DRAIN, 5'(c), 16'h0, 16'h0);

        wait_settled();
        repeat (50) @(posedge clk);
        done = 1;
        if (fail_count == 0 && pending_count == 0)
            $display("sequenced_channel_delivery_unit verification clean");
        else
            $display("sequenced_channel_delivery_unit verification failed");
        $finish;
    end

endmodule
